>>> src/eltok_pkg.sv
package eltok_pkg;

    // token kinds
    localparam logic [4:0] K_EQ     = 5'd0;
    localparam logic [4:0] K_NE     = 5'd1;
    localparam logic [4:0] K_LT     = 5'd2;
    localparam logic [4:0] K_LE     = 5'd3;
    localparam logic [4:0] K_GT     = 5'd4;
    localparam logic [4:0] K_GE     = 5'd5;
    localparam logic [4:0] K_LBRACE = 5'd6;
    localparam logic [4:0] K_RBRACE = 5'd7;
    localparam logic [4:0] K_IDENT  = 5'd8;
    localparam logic [4:0] K_PRINT  = 5'd9;
    localparam logic [4:0] K_TRUE   = 5'd10;
    localparam logic [4:0] K_FALSE  = 5'd11;
    localparam logic [4:0] K_IF     = 5'd12;
    localparam logic [4:0] K_ELSE   = 5'd13;
    localparam logic [4:0] K_ASSIGN = 5'd14;
    localparam logic [4:0] K_INT    = 5'd15;
    localparam logic [4:0] K_PLUS   = 5'd16;
    localparam logic [4:0] K_MINUS  = 5'd17;
    localparam logic [4:0] K_STAR   = 5'd18;
    localparam logic [4:0] K_SLASH  = 5'd19;
    localparam logic [4:0] K_PCT    = 5'd20;
    localparam logic [4:0] K_CARET  = 5'd21;
    localparam logic [4:0] K_LPAREN = 5'd22;
    localparam logic [4:0] K_RPAREN = 5'd23;
    localparam logic [4:0] K_EOF    = 5'd24;
    localparam logic [4:0] K_EOL    = 5'd25;
    localparam logic [4:0] K_BAD    = 5'd26;

    // held operator codes
    localparam logic [1:0] HELD_ASSIGN = 2'd0;
    localparam logic [1:0] HELD_BANG   = 2'd1;
    localparam logic [1:0] HELD_LESS   = 2'd2;
    localparam logic [1:0] HELD_GREAT  = 2'd3;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_LESS = 8'h3C;
    localparam logic [7:0] CH_GREAT = 8'h3E;

    localparam logic [15:0] WORD_LEN_MAX = 16'hFFFF;
    localparam logic [15:0] LINE_MAX     = 16'hFFFF;
    localparam logic [15:0] KW_WINDOW_BYTES = 16'd5;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_NUM,
        MODE_HELD,
        MODE_ERR
    } scan_mode_t;

    typedef struct packed {
        logic [4:0]         kind;
        logic signed [31:0] num_value;
        logic [15:0]        text_start;
        logic [15:0]        text_length;
        logic [15:0]        line_number;
        logic [7:0]         bad_char;
        logic               last;
    } token_t;

    // tokens produced by one byte, first one goes out first
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } lex_push_t;

    function automatic logic [4:0] keyword_kind(input logic [15:0] len,
                                                input logic [39:0] window);
        logic [4:0] k;
        k = K_IDENT;
        if (len == 16'd5 && window == 40'h746E697270)
            k = K_PRINT;
        else if (len == 16'd2 && window == 40'h0000006669)
            k = K_IF;
        else if (len == 16'd4 && window == 40'h0065736C65)
            k = K_ELSE;
        else if (len == 16'd4 && window == 40'h0065757274)
            k = K_TRUE;
        else if (len == 16'd5 && window == 40'h65736C6166)
            k = K_FALSE;
        return k;
    endfunction

    function automatic logic is_single(input logic [7:0] c);
        logic r;
        case (c)
            8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h5E,
            8'h28, 8'h29, 8'h7B, 8'h7D: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] single_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            8'h2B:   k = K_PLUS;
            8'h2D:   k = K_MINUS;
            8'h2A:   k = K_STAR;
            8'h2F:   k = K_SLASH;
            8'h25:   k = K_PCT;
            8'h5E:   k = K_CARET;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h7B:   k = K_LBRACE;
            8'h7D:   k = K_RBRACE;
            default: k = K_BAD;
        endcase
        return k;
    endfunction

    function automatic logic [1:0] held_code(input logic [7:0] c);
        logic [1:0] h;
        case (c)
            CH_EQ:   h = HELD_ASSIGN;
            CH_BANG: h = HELD_BANG;
            CH_LESS: h = HELD_LESS;
            default: h = HELD_GREAT;
        endcase
        return h;
    endfunction

    // held operator followed by '='
    function automatic logic [4:0] held_pair(input logic [1:0] h);
        logic [4:0] k;
        case (h)
            HELD_ASSIGN: k = K_EQ;
            HELD_BANG:   k = K_NE;
            HELD_LESS:   k = K_LE;
            default:     k = K_GE;
        endcase
        return k;
    endfunction

    // held operator followed by anything else
    function automatic logic [4:0] held_alone(input logic [1:0] h);
        logic [4:0] k;
        case (h)
            HELD_ASSIGN: k = K_ASSIGN;
            HELD_BANG:   k = K_BAD;
            HELD_LESS:   k = K_LT;
            default:     k = K_GT;
        endcase
        return k;
    endfunction

endpackage

>>> src/eltok_lexer.sv
module eltok_lexer #(
    parameter logic [15:0] OFFSET_CAP = 16'hFFFF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [7:0]           in_byte,
    output eltok_pkg::lex_push_t push
);
    import eltok_pkg::*;

    scan_mode_t         mode_reg, mode_next;
    logic [1:0]         held_reg, held_next;
    logic [31:0]        acc_reg, acc_next;
    logic [39:0]        window_reg, window_next;
    logic [15:0]        start_reg, start_next;
    logic [15:0]        len_reg, len_next;
    logic [15:0]        offset_reg, offset_next;
    logic [15:0]        line_reg, line_next;

    // character classes
    logic is_nul, is_lf, is_eq, is_alpha, is_digit, is_alnum, is_space;
    logic is_held_char, is_sgl, is_invalid;
    logic pend_continue, pend_flush, bang_fail, dispatch, pend_valid, disp_valid;

    assign is_nul   = (in_byte == CH_NUL);
    assign is_lf    = (in_byte == CH_LF);
    assign is_eq    = (in_byte == CH_EQ);
    assign is_alpha = (in_byte >= 8'h61 && in_byte <= 8'h7A) ||
                      (in_byte >= 8'h41 && in_byte <= 8'h5A) || (in_byte == CH_UNDER);
    assign is_digit = (in_byte >= CH_ZERO && in_byte <= 8'h39);
    assign is_alnum = is_alpha || is_digit;
    assign is_space = (in_byte == 8'h20) || (in_byte >= 8'h09 && in_byte <= 8'h0D);
    assign is_held_char = is_eq || (in_byte == CH_BANG) || (in_byte == CH_LESS) ||
                          (in_byte == CH_GREAT);
    assign is_sgl   = is_single(in_byte);
    assign is_invalid = !is_nul && !is_space && !is_alnum && !is_held_char && !is_sgl;

    // what the pending token does with this byte
    assign pend_continue = (mode_reg == MODE_WORD && is_alnum) ||
                           (mode_reg == MODE_NUM && is_digit) ||
                           (mode_reg == MODE_HELD && is_eq);
    assign bang_fail  = (mode_reg == MODE_HELD) && !is_eq && (held_reg == HELD_BANG);
    assign pend_flush = (mode_reg == MODE_WORD && !is_alnum) ||
                        (mode_reg == MODE_NUM && !is_digit) ||
                        (mode_reg == MODE_HELD && !is_eq && held_reg != HELD_BANG);
    assign dispatch   = (mode_reg == MODE_IDLE) || pend_flush;
    assign pend_valid = pend_flush || (mode_reg == MODE_HELD);
    // second token: fresh dispatch emits, or end of input in error paths
    assign disp_valid = (dispatch && (is_nul || is_lf || is_sgl || is_invalid)) ||
                        ((mode_reg == MODE_ERR || bang_fail) && is_nul);

    // next state
    always_comb
    begin
        mode_next   = mode_reg;
        held_next   = held_reg;
        acc_next    = acc_reg;
        window_next = window_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        offset_next = offset_reg;
        line_next   = line_reg;
        if (fire && is_nul)
        begin
            mode_next   = MODE_IDLE;
            held_next   = HELD_ASSIGN;
            acc_next    = '0;
            window_next = '0;
            start_next  = '0;
            len_next    = '0;
            offset_next = '0;
            line_next   = 16'd1;
        end
        else if (fire)
        begin
            if (mode_reg == MODE_WORD && is_alnum)
            begin
                if (len_reg < KW_WINDOW_BYTES)
                    window_next[8*len_reg[2:0] +: 8] = in_byte;
                if (len_reg != WORD_LEN_MAX)
                    len_next = len_reg + 16'd1;
            end
            if (mode_reg == MODE_NUM && is_digit)
                acc_next = (acc_reg << 3) + (acc_reg << 1) + {28'd0, in_byte[3:0]};
            if (mode_reg == MODE_HELD && is_eq)
                mode_next = MODE_IDLE;
            if (bang_fail)
                mode_next = MODE_ERR;
            if (dispatch)
            begin
                mode_next = MODE_IDLE;
                if (is_lf && line_reg != LINE_MAX)
                    line_next = line_reg + 16'd1;
                if (is_alpha)
                begin
                    mode_next   = MODE_WORD;
                    start_next  = offset_reg;
                    len_next    = 16'd1;
                    window_next = {32'd0, in_byte};
                end
                else if (is_digit)
                begin
                    mode_next = MODE_NUM;
                    acc_next  = {28'd0, in_byte[3:0]};
                end
                else if (is_held_char)
                begin
                    mode_next = MODE_HELD;
                    held_next = held_code(in_byte);
                end
                else if (is_invalid)
                    mode_next = MODE_ERR;
            end
            if ((pend_continue || dispatch) && offset_reg < OFFSET_CAP)
                offset_next = offset_reg + 16'd1;
        end
    end

    // token outputs
    always_comb
    begin
        token_t tok_a;
        token_t tok_b;
        tok_a = '0;
        tok_b = '0;
        tok_a.line_number = line_reg;
        tok_b.line_number = line_reg;
        case (mode_reg)
            MODE_WORD:
            begin
                tok_a.kind        = keyword_kind(len_reg, window_reg);
                tok_a.text_start  = start_reg;
                tok_a.text_length = len_reg;
            end
            MODE_NUM:
            begin
                tok_a.kind      = K_INT;
                tok_a.num_value = acc_reg;
            end
            MODE_HELD:
            begin
                if (is_eq)
                    tok_a.kind = held_pair(held_reg);
                else
                    tok_a.kind = held_alone(held_reg);
                if (bang_fail)
                    tok_a.bad_char = CH_BANG;
            end
            default:
                tok_a.kind = K_EOF;
        endcase
        if (is_nul)
            tok_b.kind = K_EOF;
        else if (is_lf)
            tok_b.kind = K_EOL;
        else if (is_sgl)
            tok_b.kind = single_kind(in_byte);
        else
        begin
            tok_b.kind     = K_BAD;
            tok_b.bad_char = in_byte;
        end

        push = '0;
        if (fire && pend_valid)
        begin
            push.first  = tok_a;
            push.second = tok_b;
            push.count  = disp_valid ? 2'd2 : 2'd1;
            if (disp_valid)
                push.second.last = 1'b1;
            else
                push.first.last = 1'b1;
        end
        else if (fire && disp_valid)
        begin
            push.first      = tok_b;
            push.first.last = 1'b1;
            push.count      = 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            held_reg   <= HELD_ASSIGN;
            acc_reg    <= '0;
            window_reg <= '0;
            start_reg  <= '0;
            len_reg    <= '0;
            offset_reg <= '0;
            line_reg   <= 16'd1;
        end
        else
        begin
            mode_reg   <= mode_next;
            held_reg   <= held_next;
            acc_reg    <= acc_next;
            window_reg <= window_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
            offset_reg <= offset_next;
            line_reg   <= line_next;
        end
    end

    // error mode swallows everything but nul
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && mode_reg == MODE_ERR && !is_nul) |-> push.count == 2'd0)
        else $error("byte produced a token in error mode");

    // two tokens need a pending token in front
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (mode_reg == MODE_WORD || mode_reg == MODE_NUM ||
                                  mode_reg == MODE_HELD))
        else $error("two tokens without pending token");

    // nul always rearms counters
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_nul) |=> (offset_reg == 16'd0 && line_reg == 16'd1 &&
                              mode_reg == MODE_IDLE))
        else $error("nul did not rearm");

    // line count never drops except on rearm
    assert property (@(posedge clk) disable iff (!rst_n)
        (!(fire && is_nul)) |=> (line_reg >= $past(line_reg)))
        else $error("line count went backwards");

endmodule

>>> src/eltok_queue.sv
module eltok_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  eltok_pkg::lex_push_t push,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output eltok_pkg::token_t    out_tok
);
    import eltok_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    token_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;

    assign room      = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_tok   = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> room)
        else $error("push into full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd0 && !pop) |=>
            (count_reg == $past(count_reg) && rd_ptr_reg == $past(rd_ptr_reg)))
        else $error("queue changed without push or pop");

endmodule

>>> src/expression_language_tokenizer.sv
// streaming tokenizer for a small expression language
//
// slave channel s_axis_*: one source byte per item in s_axis_tdata; a zero
// byte ends the text, flushes any pending token, emits end of input and
// rearms offset and line counters for the next text
// master channel m_axis_*: one token per item; s_axis byte causes zero, one
// or two tokens, and m_axis_tlast marks the last token caused by that byte
//
// order: a byte accepted on s_axis sits in the input register, is lexed
// and its tokens written to the queue, and output valid rises once the
// queue holds a token; the first token can then leave on the master side
// throughput: one byte per cycle while bytes give at most one token each
// and the queue has room; the two tokens of one byte leave one at a time,
// set by the single read port of the four-entry token queue
// stalls: when m_axis_tready is low the queue fills, the lexer waits once
// fewer than two entries are free, and s_axis_tready drops after the input
// register is full; nothing is lost or repeated
// reset: rst_n clears the queue, the input register and the scan state
// (idle, offset 0, line 1)
module expression_language_tokenizer #(
    parameter int SOURCE_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] source_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] num_value, [47:32] text_start, [63:48] text_length,
    // [79:64] line_number, [87:80] bad_char
    output logic [87:0] m_axis_tdata,
    output logic [4:0]  m_axis_tuser,   // [4:0] token_kind
    output logic        m_axis_tlast    // last token of this byte
);
    import eltok_pkg::*;

    // offset counter stops at the last byte position that fits 16 bits
    localparam int          CAP_INT    = (SOURCE_BYTES - 1 > 65535) ? 65535
                                                                     : SOURCE_BYTES - 1;
    localparam logic [15:0] OFFSET_CAP = CAP_INT[15:0];

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       lex_fire;
    logic       queue_room;
    lex_push_t  push;
    token_t     out_tok;

    // input register frees itself in the same cycle it is consumed
    assign lex_fire      = in_valid_reg && queue_room;
    assign s_axis_tready = !in_valid_reg || lex_fire;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
            in_valid_next = 1'b1;
        else if (lex_fire)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_byte_reg <= s_axis_tdata;
    end

    // scan state and token build
    eltok_lexer #(
        .OFFSET_CAP(OFFSET_CAP)
    ) u_lexer (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (lex_fire),
        .in_byte(in_byte_reg),
        .push   (push)
    );

    // result queue, parts lexer from the master side
    eltok_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room     (queue_room),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_tok  (out_tok)
    );

    assign m_axis_tdata = {out_tok.bad_char, out_tok.line_number, out_tok.text_length,
                           out_tok.text_start, out_tok.num_value};
    assign m_axis_tuser = out_tok.kind;
    assign m_axis_tlast = out_tok.last;

    // a held byte must not be overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !lex_fire) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("input register lost a byte");

    // the lexer only pushes when it consumed a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> lex_fire)
        else $error("token pushed without a byte");

    // token kinds stay in the defined range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= K_BAD))
        else $error("token kind out of range");

endmodule
